@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL of the downscaler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/bad_pkg.sv @@
// Shared constants of the box average downscaler.
package bad_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_SCALE  = 16;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int SCALE_W = 5;
    localparam int POS_W   = 11;
    localparam int SUB_W   = 4;
    localparam int RUN_W   = 12;
    localparam int COL_W   = 16;
    localparam int AREA_W  = 9;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_X_SCALE      = 2'd2;
    localparam logic [1:0] REG_Y_SCALE      = 2'd3;

    localparam logic [CFG_W-1:0]   RST_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0]   RST_HEIGHT = 12'd480;
    localparam logic [SCALE_W-1:0] RST_SCALE  = 5'd2;

endpackage

@@ hw/rtl/box_average_downscaler.sv @@
// Box average downscaler: top level.
// Takes RGB pixels in raster order and emits one pixel per x_scale by y_scale
// block, the truncated per-channel block average. A pixel that closes a block
// column makes the block stop taking pixels for a line store update, since the
// column sum is read from the line store, added and written back; one that
// closes a whole block also waits for the bit-serial divider that forms the
// averages and for the load of the output register, plus any wait for that
// register to free.
// After reset and after every register write the block works out the output
// size and the block position, and takes no pixel then.
`include "assert_macros.svh"

module box_average_downscaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    // pixel input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    // pixel output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic        o_m_tlast,   // row_end
    output logic        o_m_tuser    // frame_end
);
    localparam logic [1:0] ST_CALC = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    localparam int AW = $clog2(bad_pkg::MAX_WIDTH);

    // configuration registers
    logic [bad_pkg::CFG_W-1:0]   r_width, r_height;
    logic [bad_pkg::SCALE_W-1:0] r_xs, r_ys;
    logic [bad_pkg::CFG_W-1:0]   w_c, h_c;
    logic [bad_pkg::SCALE_W-1:0] xs_c, ys_c;

    logic [1:0] r_state;

    // derived sizes and position
    logic [bad_pkg::CFG_W-1:0]  r_out_w, r_out_h;
    logic [bad_pkg::AREA_W-1:0] r_area;
    logic [bad_pkg::POS_W-1:0]  r_col, r_row, r_bc, r_br;
    logic [bad_pkg::SUB_W-1:0]  r_sub_col, r_sub_row;

    // size divider
    logic [1:0]                  r_phase;
    logic [3:0]                  r_cstep;
    logic [bad_pkg::CFG_W-1:0]   r_dq;
    logic [bad_pkg::SCALE_W-1:0] r_rem;
    logic [bad_pkg::SCALE_W:0]   c_trial;
    logic [bad_pkg::SCALE_W-1:0] c_div;
    logic [bad_pkg::CFG_W-1:0]   c_dividend;

    // run and column sums
    logic [2:0][bad_pkg::RUN_W-1:0] r_run;
    logic [AW-1:0]                  r_acc_bc;
    logic                           r_acc_row0, r_acc_emit, r_acc_last_col, r_acc_last_row;
    logic [3*bad_pkg::COL_W-1:0]    c_rdata, c_wdata;
    logic                           c_we;

    // average divider
    logic [3:0]                          r_dcnt;
    logic [2:0][bad_pkg::AREA_W-1:0]     r_drem;
    logic [2:0][bad_pkg::PIX_W-1:0]      r_dlo;
    logic                                r_d_last_col, r_d_last_row;

    // output register
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic        r_out_last, r_out_user;

    logic c_accept, c_blk_valid, c_col_end, c_sub_end, c_row_wrap, c_out_slot, c_out_load;
    logic [bad_pkg::CFG_W-1:0] c_col_inc, c_row_inc;

    always_comb begin
        w_c  = (r_width == '0) ? 12'd1 :
               (r_width > 12'(bad_pkg::MAX_WIDTH)) ? 12'(bad_pkg::MAX_WIDTH) : r_width;
        h_c  = (r_height == '0) ? 12'd1 :
               (r_height > 12'(bad_pkg::MAX_HEIGHT)) ? 12'(bad_pkg::MAX_HEIGHT) : r_height;
        xs_c = (r_xs == '0) ? 5'd1 :
               (r_xs > 5'(bad_pkg::MAX_SCALE)) ? 5'(bad_pkg::MAX_SCALE) : r_xs;
        ys_c = (r_ys == '0) ? 5'd1 :
               (r_ys > 5'(bad_pkg::MAX_SCALE)) ? 5'(bad_pkg::MAX_SCALE) : r_ys;
    end

    always_comb begin
        case (r_phase)
            2'd0:    c_dividend = w_c;
            2'd1:    c_dividend = h_c;
            2'd2:    c_dividend = {1'b0, r_col};
            default: c_dividend = {1'b0, r_row};
        endcase
        c_div   = r_phase[0] ? ys_c : xs_c;
        c_trial = {r_rem, r_dq[bad_pkg::CFG_W-1]};
    end

    assign o_s_tready = (r_state == ST_RUN);
    assign c_accept   = i_s_tvalid && o_s_tready;

    assign c_blk_valid = ({1'b0, r_bc} < r_out_w) && ({1'b0, r_br} < r_out_h);
    assign c_sub_end   = ({1'b0, r_sub_col} + 5'd1) == xs_c;
    assign c_col_inc   = {1'b0, r_col} + 12'd1;
    assign c_row_inc   = {1'b0, r_row} + 12'd1;
    assign c_col_end   = c_col_inc >= w_c;
    assign c_row_wrap  = c_row_inc >= h_c;
    assign c_out_slot  = !r_out_valid || i_m_tready;
    assign c_out_load  = !i_cfg_we && (r_state == ST_DIV) && (r_dcnt == 4'd8) && c_out_slot;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            c_wdata[c*bad_pkg::COL_W +: bad_pkg::COL_W] =
                (r_acc_row0 ? 16'd0 : c_rdata[c*bad_pkg::COL_W +: bad_pkg::COL_W])
                + {4'd0, r_run[c]};
        end
        c_we = (r_state == ST_ACC);
    end

    bad_ram #(
        .WIDTH(3*bad_pkg::COL_W),
        .DEPTH(bad_pkg::MAX_WIDTH)
    ) u_col_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(r_acc_bc),
        .i_wdata(c_wdata),
        .i_raddr(r_bc[AW-1:0]),
        .o_rdata(c_rdata)
    );

    // output valid: set when the averages load, drop on the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= bad_pkg::RST_WIDTH;
            r_height    <= bad_pkg::RST_HEIGHT;
            r_xs        <= bad_pkg::RST_SCALE;
            r_ys        <= bad_pkg::RST_SCALE;
            r_state     <= ST_CALC;
            r_phase     <= 2'd0;
            r_cstep     <= 4'd13;
            r_col       <= '0;
            r_row       <= '0;
            r_bc        <= '0;
            r_br        <= '0;
            r_sub_col   <= '0;
            r_sub_row   <= '0;
            r_run       <= '0;
            r_dcnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bad_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    bad_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    bad_pkg::REG_X_SCALE:      r_xs     <= i_cfg_data[4:0];
                    bad_pkg::REG_Y_SCALE:      r_ys     <= i_cfg_data[4:0];
                    default: ;
                endcase
                // rework sizes and block position under the new settings
                r_state <= ST_CALC;
                r_phase <= 2'd0;
                r_cstep <= 4'd13;
            end else begin
                case (r_state)
                    ST_CALC: begin
                        if (r_cstep == 4'd13) begin
                            r_dq    <= c_dividend;
                            r_rem   <= '0;
                            r_cstep <= 4'd0;
                            r_area  <= {4'd0, xs_c} * {4'd0, ys_c};
                        end else if (r_cstep == 4'd12) begin
                            case (r_phase)
                                2'd0: r_out_w <= r_dq;
                                2'd1: r_out_h <= r_dq;
                                2'd2: begin
                                    r_bc      <= r_dq[bad_pkg::POS_W-1:0];
                                    r_sub_col <= r_rem[bad_pkg::SUB_W-1:0];
                                end
                                default: begin
                                    r_br      <= r_dq[bad_pkg::POS_W-1:0];
                                    r_sub_row <= r_rem[bad_pkg::SUB_W-1:0];
                                end
                            endcase
                            r_cstep <= 4'd13;
                            r_phase <= r_phase + 2'd1;
                            if (r_phase == 2'd3) begin
                                r_state <= ST_RUN;
                            end
                        end else begin
                            if (c_trial >= {1'b0, c_div}) begin
                                r_rem <= 5'(c_trial - {1'b0, c_div});
                                r_dq  <= {r_dq[bad_pkg::CFG_W-2:0], 1'b1};
                            end else begin
                                r_rem <= c_trial[bad_pkg::SCALE_W-1:0];
                                r_dq  <= {r_dq[bad_pkg::CFG_W-2:0], 1'b0};
                            end
                            r_cstep <= r_cstep + 4'd1;
                        end
                    end
                    ST_RUN: begin
                        if (c_accept) begin
                            if (c_blk_valid) begin
                                for (int c = 0; c < 3; c++) begin
                                    r_run[c] <= (r_sub_col == '0 ? 12'd0 : r_run[c])
                                                + {4'd0, i_s_tdata[c*8 +: 8]};
                                end
                                if (c_sub_end) begin
                                    // column sum read issued this cycle
                                    r_state        <= ST_ACC;
                                    r_acc_bc       <= r_bc[AW-1:0];
                                    r_acc_row0     <= (r_sub_row == '0);
                                    r_acc_emit     <= ({1'b0, r_sub_row} + 5'd1) == ys_c;
                                    r_acc_last_col <= ({1'b0, r_bc} + 12'd1) == r_out_w;
                                    r_acc_last_row <= ({1'b0, r_br} + 12'd1) == r_out_h;
                                end
                            end
                            if (c_col_end) begin
                                r_col     <= '0;
                                r_bc      <= '0;
                                r_sub_col <= '0;
                                if (c_row_wrap || ({1'b0, r_sub_row} + 5'd1) == ys_c) begin
                                    r_sub_row <= '0;
                                end else begin
                                    r_sub_row <= r_sub_row + 4'd1;
                                end
                                if (c_row_wrap) begin
                                    r_row <= '0;
                                    r_br  <= '0;
                                end else begin
                                    r_row <= c_row_inc[bad_pkg::POS_W-1:0];
                                    if (({1'b0, r_sub_row} + 5'd1) == ys_c) begin
                                        r_br <= r_br + 11'd1;
                                    end
                                end
                            end else begin
                                r_col <= c_col_inc[bad_pkg::POS_W-1:0];
                                if (c_sub_end) begin
                                    r_sub_col <= '0;
                                    r_bc      <= r_bc + 11'd1;
                                end else begin
                                    r_sub_col <= r_sub_col + 4'd1;
                                end
                            end
                        end
                    end
                    ST_ACC: begin
                        if (r_acc_emit) begin
                            for (int c = 0; c < 3; c++) begin
                                r_drem[c] <= {1'b0, c_wdata[c*16+8 +: 8]};
                                r_dlo[c]  <= c_wdata[c*16 +: 8];
                            end
                            r_d_last_col <= r_acc_last_col;
                            r_d_last_row <= r_acc_last_row;
                            r_dcnt       <= '0;
                            r_state      <= ST_DIV;
                        end else begin
                            r_state <= ST_RUN;
                        end
                    end
                    default: begin
                        if (r_dcnt == 4'd8) begin
                            // hold the averages until the output register frees
                            if (c_out_slot) begin
                                r_out_data  <= {r_dlo[2], r_dlo[1], r_dlo[0]};
                                r_out_last  <= r_d_last_col;
                                r_out_user  <= r_d_last_col && r_d_last_row;
                                r_state     <= ST_RUN;
                            end
                        end else begin
                            for (int c = 0; c < 3; c++) begin
                                if ({r_drem[c], r_dlo[c][7]} >= {1'b0, r_area}) begin
                                    r_drem[c] <= 9'({r_drem[c], r_dlo[c][7]} - {1'b0, r_area});
                                    r_dlo[c]  <= {r_dlo[c][6:0], 1'b1};
                                end else begin
                                    r_drem[c] <= {r_drem[c][7:0], r_dlo[c][7]};
                                    r_dlo[c]  <= {r_dlo[c][6:0], 1'b0};
                                end
                            end
                            r_dcnt <= r_dcnt + 4'd1;
                        end
                    end
                endcase
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

    `ASSERT_CLK(a_sub_col_range, (r_state == ST_RUN) |-> ({1'b0, r_sub_col} < xs_c), "sub column beyond block")
    `ASSERT_CLK(a_acc_one_cycle, (r_state == ST_ACC) && !i_cfg_we |=> (r_state != ST_ACC), "line store update overlaps")
    `ASSERT_CLK(a_div_count, r_dcnt <= 4'd8, "average divider overran")
    `ASSERT_CLK(a_frame_end_row_end, o_m_tvalid && o_m_tuser |-> o_m_tlast, "frame end without row end")

endmodule

@@ hw/rtl/bad_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module bad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ tb/sv/box_average_downscaler_tb.sv @@
// Self-checking testbench for the box average downscaler.
module box_average_downscaler_tb;

    localparam int SETTLE_CYC = 40;
    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_CYC   = 300;

    typedef struct packed {
        logic [23:0] rgb;
        logic        row_end;
        logic        frame_end;
    } t_pix_out;

    typedef enum logic [1:0] {ROW_CFG, ROW_SYNC, ROW_PIX, ROW_CHK} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [11:0] val;
        logic [23:0] pix;
        t_pix_out    want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [11:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;

    box_average_downscaler uut (.*);

    always #5 i_clk = ~i_clk;

    // scaler model state
    logic [11:0] cfg_width, cfg_height;
    logic [4:0]  cfg_xs, cfg_ys;
    int unsigned col_sum [bad_pkg::MAX_WIDTH][3];
    int unsigned run_acc [3];
    int unsigned pos_col, pos_row;

    t_pix_out    avg_q[$];
    t_stim_row   stim_tab[$];
    int          fails = 0;
    int          send_idle = 15, recv_idle = 82;
    bit          hold_req = 1'b0;
    int          fed = 0;

    function automatic int unsigned clampv(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    task automatic scale_pixel(input logic [23:0] d, output bit hit, output t_pix_out r);
        int unsigned w, h, xs, ys, ow, oh, sc, sr, bc, br, cnt;
        int unsigned px [3];
        w  = clampv(32'(cfg_width), bad_pkg::MAX_WIDTH);
        h  = clampv(32'(cfg_height), bad_pkg::MAX_HEIGHT);
        xs = clampv(32'(cfg_xs), bad_pkg::MAX_SCALE);
        ys = clampv(32'(cfg_ys), bad_pkg::MAX_SCALE);
        ow = w / xs;
        oh = h / ys;
        px[0] = 32'(d[7:0]);
        px[1] = 32'(d[15:8]);
        px[2] = 32'(d[23:16]);
        hit = 1'b0;
        r = '0;
        sc = pos_col % xs;
        sr = pos_row % ys;
        if (pos_col < ow * xs && pos_row < oh * ys) begin
            bc = pos_col / xs;
            br = pos_row / ys;
            for (int c = 0; c < 3; c++)
                run_acc[c] = (sc == 0 ? 0 : run_acc[c]) + px[c];
            if (sc == xs - 1) begin
                for (int c = 0; c < 3; c++)
                    col_sum[bc][c] = (sr == 0 ? 0 : col_sum[bc][c]) + run_acc[c];
                if (sr == ys - 1) begin
                    cnt = xs * ys;
                    for (int c = 0; c < 3; c++)
                        r.rgb[8*c +: 8] = 8'(col_sum[bc][c] / cnt);
                    r.row_end = (bc == ow - 1);
                    r.frame_end = (bc == ow - 1) && (br == oh - 1);
                    hit = 1'b1;
                end
            end
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h) pos_row = 0;
        end
    endtask

    // Offer one pixel, hold it until the transfer, then predict.
    task automatic send_pixel(input logic [23:0] d, input bit typed, input t_pix_out want);
        bit hit;
        t_pix_out r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = d;
        do @(posedge i_clk); while (!o_s_tready);
        scale_pixel(d, hit, r);
        if (typed) avg_q.push_back(want);
        else if (hit) avg_q.push_back(r);
        fed++;
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (avg_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [11:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        case (idx)
            bad_pkg::REG_IMAGE_WIDTH:  cfg_width = val;
            bad_pkg::REG_IMAGE_HEIGHT: cfg_height = val;
            bad_pkg::REG_X_SCALE:      cfg_xs = val[4:0];
            bad_pkg::REG_Y_SCALE:      cfg_ys = val[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Feed filler pixels until the frame position is back at the origin.
    task automatic sync_origin();
        while (pos_col != 0 || pos_row != 0)
            send_pixel(24'($urandom), 1'b0, '0);
    endtask

    task automatic run_phase(input logic [11:0] w, input logic [11:0] h,
                             input logic [11:0] xs, input logic [11:0] ys,
                             input int frames);
        int unsigned n;
        quiesce();
        cfg_write(bad_pkg::REG_IMAGE_WIDTH, w);
        cfg_write(bad_pkg::REG_IMAGE_HEIGHT, h);
        cfg_write(bad_pkg::REG_X_SCALE, xs);
        cfg_write(bad_pkg::REG_Y_SCALE, ys);
        sync_origin();
        n = 32'(frames) * clampv(32'(cfg_width), bad_pkg::MAX_WIDTH)
            * clampv(32'(cfg_height), bad_pkg::MAX_HEIGHT);
        repeat (n) send_pixel(24'($urandom), 1'b0, '0);
    endtask

    function automatic void add_row(t_row_kind k, logic [1:0] idx, logic [11:0] val,
                                    logic [23:0] pix, logic [23:0] rgb, logic re, logic fe);
        t_stim_row s;
        s.kind = k;
        s.idx = idx;
        s.val = val;
        s.pix = pix;
        s.want = '{rgb: rgb, row_end: re, frame_end: fe};
        stim_tab.push_back(s);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_pix_out e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (avg_q.size() == 0) begin
                $error("unexpected output pixel %h", o_m_tdata);
                fails++;
            end else begin
                e = avg_q.pop_front();
                if (o_m_tdata[7:0] !== e.rgb[7:0]) begin
                    $error("red_out: expected %0d, got %0d", e.rgb[7:0], o_m_tdata[7:0]);
                    fails++;
                end
                if (o_m_tdata[15:8] !== e.rgb[15:8]) begin
                    $error("green_out: expected %0d, got %0d", e.rgb[15:8], o_m_tdata[15:8]);
                    fails++;
                end
                if (o_m_tdata[23:16] !== e.rgb[23:16]) begin
                    $error("blue_out: expected %0d, got %0d", e.rgb[23:16], o_m_tdata[23:16]);
                    fails++;
                end
                if (o_m_tlast !== e.row_end) begin
                    $error("row_end: expected %0b, got %0b", e.row_end, o_m_tlast);
                    fails++;
                end
                if (o_m_tuser !== e.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", e.frame_end, o_m_tuser);
                    fails++;
                end
            end
        end
    end

    // output backpressure, with one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYC;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else begin
                i_m_tready = ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= WDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int rnd_items;
        cfg_width = bad_pkg::RST_WIDTH;
        cfg_height = bad_pkg::RST_HEIGHT;
        cfg_xs = bad_pkg::RST_SCALE;
        cfg_ys = bad_pkg::RST_SCALE;
        pos_col = 0;
        pos_row = 0;
        run_acc = '{default: 0};

        // two-pixel averaging: 0 and 255 give 127 in a channel
        add_row(ROW_CFG, bad_pkg::REG_IMAGE_WIDTH, 12'd2, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CFG, bad_pkg::REG_IMAGE_HEIGHT, 12'd1, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CFG, bad_pkg::REG_X_SCALE, 12'd2, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CFG, bad_pkg::REG_Y_SCALE, 12'd1, '0, '0, 1'b0, 1'b0);
        add_row(ROW_SYNC, '0, '0, '0, '0, 1'b0, 1'b0);
        add_row(ROW_PIX, '0, '0, 24'h000000, '0, 1'b0, 1'b0);
        add_row(ROW_CHK, '0, '0, 24'hffffff, 24'h7f7f7f, 1'b1, 1'b1);
        add_row(ROW_PIX, '0, '0, 24'h0000ff, '0, 1'b0, 1'b0);
        add_row(ROW_CHK, '0, '0, 24'h00ff00, 24'h007f7f, 1'b1, 1'b1);
        // frame smaller than one block: nothing comes out
        add_row(ROW_CFG, bad_pkg::REG_IMAGE_WIDTH, 12'd3, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CFG, bad_pkg::REG_IMAGE_HEIGHT, 12'd3, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CFG, bad_pkg::REG_X_SCALE, 12'd4, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CFG, bad_pkg::REG_Y_SCALE, 12'd4, '0, '0, 1'b0, 1'b0);
        add_row(ROW_SYNC, '0, '0, '0, '0, 1'b0, 1'b0);
        for (int i = 0; i < 9; i++) add_row(ROW_PIX, '0, '0, 24'h5a5a5a, '0, 1'b0, 1'b0);
        // zero scales act as 1: each pixel passes straight through
        add_row(ROW_CFG, bad_pkg::REG_IMAGE_WIDTH, 12'd1, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CFG, bad_pkg::REG_IMAGE_HEIGHT, 12'd1, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CFG, bad_pkg::REG_X_SCALE, 12'd0, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CFG, bad_pkg::REG_Y_SCALE, 12'd0, '0, '0, 1'b0, 1'b0);
        add_row(ROW_SYNC, '0, '0, '0, '0, 1'b0, 1'b0);
        add_row(ROW_CHK, '0, '0, 24'habcdef, 24'habcdef, 1'b1, 1'b1);
        add_row(ROW_CHK, '0, '0, 24'hffffff, 24'hffffff, 1'b1, 1'b1);
        add_row(ROW_CHK, '0, '0, 24'h000000, 24'h000000, 1'b1, 1'b1);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: the start of the first row, taken once size setup ends
        repeat (16) send_pixel(24'($urandom), 1'b0, '0);

        for (int i = 0; i < stim_tab.size(); i++) begin
            if (stim_tab[i].kind == ROW_CFG) begin
                if (i == 0 || stim_tab[i-1].kind != ROW_CFG) quiesce();
                cfg_write(stim_tab[i].idx, stim_tab[i].val);
            end else if (stim_tab[i].kind == ROW_SYNC) begin
                sync_origin();
            end else begin
                send_pixel(stim_tab[i].pix, stim_tab[i].kind == ROW_CHK, stim_tab[i].want);
            end
        end

        // long output stall while a small frame keeps streaming in
        hold_req = 1'b1;
        run_phase(12'd8, 12'd4, 12'd2, 12'd2, 1);

        // random small frames, idling pattern switching as the count grows
        fed = 0;
        rnd_items = 0;
        while (rnd_items < 180) begin
            if (rnd_items < 60) begin
                send_idle = 15;
                recv_idle = 82;
            end else if (rnd_items < 120) begin
                send_idle = 82;
                recv_idle = 15;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            run_phase(12'($urandom_range(1, 16)), 12'($urandom_range(1, 8)),
                      12'(($urandom_range(0, 5) == 0) ? $urandom_range(1, 16)
                                                     : $urandom_range(1, 4)),
                      12'($urandom_range(1, 4)), int'($urandom_range(1, 2)));
            rnd_items = fed;
        end

        // out-of-range sizes and scales, and the largest block
        run_phase(12'd0, 12'd0, 12'd31, 12'd0, 2);
        run_phase(12'd16, 12'd1, 12'd31, 12'd0, 1);
        run_phase(12'd1, 12'd16, 12'd0, 12'd17, 1);
        run_phase(12'd16, 12'd16, 12'd16, 12'd16, 1);

        quiesce();
        if (fails == 0 && avg_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
